/* hw/rtl/dbc_pkg.sv */
// Shared types and constants for the double-byte code collector.
package dbc_pkg;

  localparam int GRID_SIDE = 94;
  localparam int MAP_SIZE  = GRID_SIDE * GRID_SIDE;
  localparam int IDX_W     = $clog2(MAP_SIZE + 1);
  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int COUNT_W   = 14;
  localparam int CODE_W    = 16;

  localparam logic [7:0] CODE_BASE  = 8'hA1;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_COMMENT   = 2'd1;
  localparam logic [1:0] MODE_SKIP_FLAG = 2'd2;

  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FETCH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic               added_new;
    logic [COUNT_W-1:0] distinct_count;
    logic [CODE_W-1:0]  used_code;
    logic               code_valid;
    logic               walk_done;
  } res_t;

endpackage

/* hw/rtl/dbc_ram.sv */
// Generic single-port RAM with registered read.
module dbc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/dbc_front.sv */
// Front end: text parser state and classification of each accepted beat.
module dbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          operation,
  input  logic [7:0]    text_byte,
  output dbc_pkg::cmd_t cmd
);
  import dbc_pkg::*;

  logic [1:0] mode, mode_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;

  logic [7:0] h_off, b_off;
  logic       h_in, b_in, decided;

  assign h_off = held_byte - CODE_BASE;
  assign b_off = text_byte - CODE_BASE;
  assign h_in  = (held_byte >= CODE_BASE) && (h_off < 8'(GRID_SIDE));
  assign b_in  = (text_byte >= CODE_BASE) && (b_off < 8'(GRID_SIDE));

  always_comb begin
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    decided         = 1'b0;
    cmd.kind        = CMD_PLAIN;
    cmd.idx         = IDX_W'(h_off[ROW_W-1:0]) * IDX_W'(GRID_SIDE)
                    + IDX_W'(b_off[ROW_W-1:0]);
    if (operation) begin
      cmd.kind = CMD_FETCH;
    end else if (mode[1]) begin
      if (text_byte == CHAR_NL) begin
        mode_next = mode & MODE_COMMENT;
      end
    end else begin
      if (held_valid) begin
        held_valid_next = 1'b0;
        if (mode == MODE_NORMAL) begin
          if (h_in && b_in) begin
            cmd.kind = CMD_MARK;
            decided  = 1'b1;
          end else if (held_byte == CHAR_SLASH && text_byte == CHAR_SLASH) begin
            mode_next = MODE_SKIP_FLAG | MODE_NORMAL;
            decided   = 1'b1;
          end else if (held_byte == CHAR_SLASH && text_byte == CHAR_STAR) begin
            mode_next = MODE_COMMENT;
            decided   = 1'b1;
          end
        end else if (held_byte == CHAR_STAR && text_byte == CHAR_SLASH) begin
          mode_next = MODE_NORMAL;
          decided   = 1'b1;
        end
      end
      if (!decided) begin
        if (text_byte == CHAR_NUL) begin
          mode_next = mode | MODE_SKIP_FLAG;
        end else if (text_byte != CHAR_NL) begin
          held_byte_next  = text_byte;
          held_valid_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      held_byte  <= '0;
      held_valid <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
    end
  end

endmodule

/* hw/rtl/dbc_cmd_fifo.sv */
// Two-entry command queue between front end and bitmap engine.
module dbc_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  dbc_pkg::cmd_t wr_cmd,
  input  logic          rd,
  output dbc_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import dbc_pkg::*;

  cmd_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign full   = (fill == 2'd2);
  assign empty  = (fill == 2'd0);
  assign rd_cmd = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hw/rtl/dbc_back.sv */
// Back end: bitmap clear, code marking, ordered walk and result register.
module dbc_back (
  input  logic          clk,
  input  logic          rst,
  input  dbc_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  output logic          clearing,
  input  logic          pop,
  output logic          res_valid,
  output dbc_pkg::res_t res
);
  import dbc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_MARK  = 4'b0100,
    S_WALK  = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [IDX_W-1:0]   clear_addr, clear_addr_next;
  logic [IDX_W-1:0]   mark_idx, mark_idx_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [IDX_W-1:0]   cursor, cursor_next, cursor_inc;
  logic [ROW_W-1:0]   row, row_next, row_inc;
  logic [ROW_W-1:0]   col, col_next, col_inc;

  logic             ram_we, ram_wdata, ram_rdata;
  logic [IDX_W-1:0] ram_addr;
  logic             res_load, out_free;
  res_t             res_next;

  dbc_ram #(.WIDTH(1), .DEPTH(MAP_SIZE)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign clearing   = (state == S_CLEAR);
  assign out_free   = !res_valid || pop;
  assign cursor_inc = cursor + IDX_W'(1);
  assign col_inc    = (col == ROW_W'(GRID_SIDE - 1)) ? '0 : col + ROW_W'(1);
  assign row_inc    = (col == ROW_W'(GRID_SIDE - 1)) ? row + ROW_W'(1) : row;

  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    mark_idx_next   = mark_idx;
    count_next      = count;
    cursor_next     = cursor;
    row_next        = row;
    col_next        = col;
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_wdata       = 1'b0;
    ram_addr        = cursor;
    res_load        = 1'b0;
    res_next        = '0;
    res_next.distinct_count = count;
    unique case (state)
      S_CLEAR: begin
        ram_we          = 1'b1;
        ram_addr        = clear_addr;
        clear_addr_next = clear_addr + IDX_W'(1);
        if (clear_addr == IDX_W'(MAP_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_MARK: begin
              ram_addr      = cmd.idx;
              mark_idx_next = cmd.idx;
              state_next    = S_MARK;
            end
            CMD_FETCH: begin
              if (cursor == IDX_W'(MAP_SIZE)) begin
                res_load           = 1'b1;
                res_next.walk_done = 1'b1;
              end else begin
                state_next = S_WALK;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_MARK: begin
        res_load   = 1'b1;
        state_next = S_IDLE;
        if (!ram_rdata) begin
          ram_we                  = 1'b1;
          ram_wdata               = 1'b1;
          ram_addr                = mark_idx;
          count_next              = count + COUNT_W'(1);
          res_next.added_new      = 1'b1;
          res_next.distinct_count = count + COUNT_W'(1);
        end
      end
      S_WALK: begin
        cursor_next = cursor_inc;
        row_next    = row_inc;
        col_next    = col_inc;
        if (ram_rdata) begin
          res_load            = 1'b1;
          res_next.code_valid = 1'b1;
          res_next.used_code  = {8'(row) + CODE_BASE, 8'(col) + CODE_BASE};
          state_next          = S_IDLE;
        end else if (cursor_inc == IDX_W'(MAP_SIZE)) begin
          res_load           = 1'b1;
          res_next.walk_done = 1'b1;
          state_next         = S_IDLE;
        end else begin
          ram_addr = cursor_inc;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      count      <= '0;
      cursor     <= '0;
      row        <= '0;
      col        <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      count      <= count_next;
      cursor     <= cursor_next;
      row        <= row_next;
      col        <= col_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mark_idx <= mark_idx_next;
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

/* hw/rtl/double_byte_code_collector.sv */
// Top level of the double-byte code collector.
//
//   channel   handshake         payload
//   input     push / full       operation, text_byte
//   result    pop / empty       added_new, distinct_count, used_code, code_valid, walk_done
//
// Plain text beat: answered from S_IDLE; a code pair: bitmap read in S_IDLE, then write in S_MARK.
// Fetch: bitmap bits are scanned from the cursor in S_WALK, one per cycle on the
// single bitmap RAM port.
// After reset the bitmap is cleared one bit per cycle, with full held high.
// A two-entry queue lets the parser take beats while the engine works; the engine
// stalls only while the result register is held.
module double_byte_code_collector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         operation,
  input  logic [7:0]                   text_byte,
  output logic                         empty,
  input  logic                         pop,
  output logic                         added_new,
  output logic [dbc_pkg::COUNT_W-1:0]  distinct_count,
  output logic [dbc_pkg::CODE_W-1:0]   used_code,
  output logic                         code_valid,
  output logic                         walk_done
);
  import dbc_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic accept, q_full, q_empty, q_pop, clearing, res_valid, pop_acc;

  assign full    = q_full || clearing;
  assign accept  = push && !full;
  assign empty   = !res_valid;
  assign pop_acc = pop && res_valid;

  dbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .text_byte (text_byte),
    .cmd       (in_cmd)
  );

  dbc_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_cmd (in_cmd),
    .rd     (q_pop),
    .rd_cmd (q_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  dbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (!q_empty),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .pop       (pop_acc),
    .res_valid (res_valid),
    .res       (res)
  );

  assign added_new      = res.added_new;
  assign distinct_count = res.distinct_count;
  assign used_code      = res.used_code;
  assign code_valid     = res.code_valid;
  assign walk_done      = res.walk_done;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clearing |-> full) else $error("input open during bitmap clear");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> distinct_count <= COUNT_W'(MAP_SIZE)) else $error("count out of range");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    !empty |-> $onehot0({added_new, code_valid, walk_done}))
    else $error("result mixes scan and fetch flags");

  a_no_result_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> empty) else $error("result during bitmap clear");
`endif

endmodule
